[rtl/core/pulse_train_ramp_timer_planner_macros.svh]
// Assertion helpers for the pulse train ramp planner.
`ifndef PULSE_TRAIN_RAMP_TIMER_PLANNER_MACROS_SVH
`define PULSE_TRAIN_RAMP_TIMER_PLANNER_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define PTRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ptrp_pkg.sv]
`timescale 1ns / 1ps
package ptrp_pkg;
  localparam int unsigned Channels = 6;
  localparam int unsigned ChW = 3;
  localparam int unsigned ChIdxW = (Channels > 1) ? $clog2(Channels) : 1;

  localparam logic [15:0] IdleReload = 16'd49999;
  localparam logic [11:0] IdlePrescaler = 12'd100;
  localparam logic [9:0] Permille = 10'd1000;

  // x / 1000 as (x * RcpPermille) >> RcpShift, exact for x below 2^26
  localparam logic [26:0] RcpPermille = 27'd68719477;
  localparam int unsigned RcpShift = 36;

  localparam logic [27:0] RstTimerClk = 28'd84000000;
  localparam logic [15:0] RstRampIntv = 16'd100;
  localparam logic [15:0] RstStartFreq = 16'd10;
  localparam logic [19:0] RstFreeMax = 20'd5000;

  typedef enum logic [1:0] {
    ActWrite  = 2'd0,
    ActTick   = 2'd1,
    ActUpdate = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RegTimerClk = 2'd0,
    RegRampIntv = 2'd1,
    RegStartFreq = 2'd2,
    RegFreeMax  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StRamp,
    StUpdPrep,
    StDiv1,
    StDiv2,
    StMul,
    StRcp,
    StOut
  } state_e;

  // Divider operand select.
  typedef enum logic {
    DivFreq = 1'b0,   // timer clock / frequency
    DivPsc  = 1'b1    // first quotient / (prescaler + 1)
  } div_sel_e;

  // Controller -> datapath commands.
  typedef struct packed {
    logic accept;       // latch input item
    logic tick_inc;     // advance divider
    logic ramp_start;   // clear ramp index
    logic ramp_step;    // ramp one channel
    logic upd_prep;     // store write item; enable edge and pulse bookkeeping
    logic div_start;    // start divider with selected operands
    div_sel_e div_sel;
    logic mul_load;
    logic rcp_load;
    logic out_load;
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic ramp_due;
    logic ramp_last;
    logic ch_valid;
    logic active;
    logic div_done;
  } status_t;
endpackage

[rtl/core/pulse_train_ramp_timer_planner.sv]
`timescale 1ns / 1ps
// Channel     | Dir | Handshake            | Payload
// s_axis      | in  | tvalid/tready        | tdata job/channel, tuser action
// m_axis      | out | tvalid/tready        | tdata timer values and flags
// cfg         | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
// Write: latch, then store. Tick: latch, advance the tick divider and, if due,
// ramp each channel (one channel per cycle). Update: two passes of a 28-step
// divider, duty multiply and reciprocal scale by 1000. One item at a time; the
// result sits in an output register, so the next item is taken while it waits;
// an update stalls until the previous result has transferred. Async active-low
// reset restores control, config and channel state, not item or result regs.
module pulse_train_ramp_timer_planner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] channel, [3] enable, [27:4] pulse_count, [47:28] target_freq,
  // [63:48] accel_step, [73:64] duty_permille
  input  logic [79:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] out_channel, [14:3] prescaler, [30:15] reload, [46:31] compare,
  // [47] counter_restart, [48] job_finished, [49] enabled_now
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [27:0] cfg_data
);
  import ptrp_pkg::*;
  cmd_t cmd;
  status_t sts;
  logic [1:0] act;
  logic [51:0] otd;
  logic [73:0] itd;

  assign itd = s_axis_tdata[73:0];
  assign cfg_ready = 1'b1;
  assign m_axis_tdata = {4'd0, otd};

  ptrp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .act_i(act), .sts_i(sts), .cmd_o(cmd)
  );

  ptrp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .in_tdata_i(itd), .in_tuser_i(s_axis_tuser),
    .cfg_valid_i(cfg_valid), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .act_o(act), .out_tdata_o(otd)
  );
endmodule

[rtl/core/ptrp_divider.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 28-bit operands.
module ptrp_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [27:0] num_i,
  input  logic [27:0] den_i,
  output logic        done_o,
  output logic [27:0] quot_o
);
  logic [27:0] q_q, q_d;
  logic [28:0] r_q, r_d;
  logic [27:0] den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [28:0] trial;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {r_q[27:0], q_q[27]} - {1'b0, den_q};
    if (start_i) begin
      q_d = num_i;
      r_d = '0;
      den_d = den_i;
      cnt_d = 5'd28;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[28]) begin
        r_d = trial;
        q_d = {q_q[26:0], 1'b1};
      end else begin
        r_d = {r_q[27:0], q_q[27]};
        q_d = {q_q[26:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

[rtl/core/ptrp_datapath.sv]
`timescale 1ns / 1ps
`include "pulse_train_ramp_timer_planner_macros.svh"
module ptrp_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptrp_pkg::cmd_t       cmd_i,
  output ptrp_pkg::status_t    sts_o,
  input  logic [73:0]          in_tdata_i,
  input  logic [1:0]           in_tuser_i,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [27:0]          cfg_data_i,
  output logic [1:0]           act_o,
  output logic [51:0]          out_tdata_o
);
  import ptrp_pkg::*;

  localparam logic [ChIdxW-1:0] LastCh = ChIdxW'(Channels - 1);

  logic [27:0] timer_clk_q;
  logic [15:0] ramp_intv_q, start_freq_q;
  logic [19:0] free_max_q;

  logic [Channels-1:0] en_q, prev_q, armed_q, seek_q;
  logic [23:0] total_q [Channels];
  logic [23:0] left_q  [Channels];
  logic [23:0] decel_q [Channels];
  logic [19:0] cur_q   [Channels];
  logic [19:0] goal_q  [Channels];
  logic [15:0] step_q  [Channels];
  logic [9:0]  duty_q  [Channels];
  logic [15:0] tick_q;

  // latched item
  logic [1:0]  act_q;
  logic [2:0]  ch_q;
  logic        wen_q;
  logic [23:0] wcnt_q;
  logic [19:0] wgoal_q;
  logic [15:0] wstep_q;
  logic [9:0]  wduty_q;

  logic [ChIdxW-1:0] ridx_q;
  logic [ChIdxW-1:0] sel;
  logic [27:0] div_q1_q;
  logic [11:0] psc_q;
  logic [15:0] arr_q;
  logic [25:0] prod_q;
  logic [52:0] rcp_q;
  logic        restart_q;
  logic [9:0]  dcl;

  logic        div_start, div_done;
  logic [27:0] div_num, div_den, div_quot;
  logic [16:0] tick_inc;

  assign sel = ch_q[ChIdxW-1:0];
  assign act_o = act_q;
  assign tick_inc = {1'b0, tick_q} + 17'd1;
  assign dcl = (duty_q[sel] > Permille) ? Permille : duty_q[sel];

  always_comb begin
    case (cmd_i.div_sel)
      DivFreq: begin
        div_num = timer_clk_q;
        div_den = (cur_q[sel] == '0) ? 28'd1 : {8'd0, cur_q[sel]};
      end
      DivPsc: begin
        div_num = div_q1_q;
        div_den = {16'd0, psc_q} + 28'd1;
      end
      default: begin
        div_num = timer_clk_q;
        div_den = 28'd1;
      end
    endcase
  end
  assign div_start = cmd_i.div_start;

  ptrp_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  assign sts_o.ramp_due = (tick_inc[15:0] > ramp_intv_q);
  assign sts_o.ramp_last = (ridx_q == LastCh);
  assign sts_o.ch_valid = ({29'd0, ch_q} < 32'(Channels)) && (act_q != ActNone);
  assign sts_o.active = en_q[sel] && (left_q[sel] != '0 || total_q[sel] == '0);
  assign sts_o.div_done = div_done;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_clk_q <= RstTimerClk;
      ramp_intv_q <= RstRampIntv;
      start_freq_q <= RstStartFreq;
      free_max_q <= RstFreeMax;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegTimerClk:  timer_clk_q <= cfg_data_i;
        RegRampIntv:  ramp_intv_q <= cfg_data_i[15:0];
        RegStartFreq: start_freq_q <= cfg_data_i[15:0];
        RegFreeMax:   free_max_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q <= in_tuser_i;
      ch_q <= in_tdata_i[2:0];
      wen_q <= in_tdata_i[3];
      wcnt_q <= in_tdata_i[27:4];
      wgoal_q <= in_tdata_i[47:28];
      wstep_q <= in_tdata_i[63:48];
      wduty_q <= in_tdata_i[73:64];
    end
    if (div_done) begin
      case (cmd_i.div_sel)
        DivFreq: begin
          div_q1_q <= div_quot;
          psc_q <= div_quot[27:16];   // divide by 0x10000
        end
        DivPsc: arr_q <= div_quot[15:0];
        default: ;
      endcase
    end
    if (cmd_i.mul_load) prod_q <= {16'd0, dcl} * {10'd0, arr_q};
    if (cmd_i.rcp_load) rcp_q <= {27'd0, prod_q} * {26'd0, RcpPermille};
    if (cmd_i.upd_prep) begin
      restart_q <= en_q[sel] && !prev_q[sel];
    end
    if (cmd_i.out_load) begin
      out_tdata_o[2:0] <= ch_q;
      out_tdata_o[14:3] <= sts_o.active ? psc_q : IdlePrescaler;
      out_tdata_o[30:15] <= sts_o.active ? arr_q : IdleReload;
      out_tdata_o[46:31] <= sts_o.active ? rcp_q[RcpShift +: 16] : 16'd0;
      out_tdata_o[47] <= restart_q;
      out_tdata_o[48] <= !sts_o.active && en_q[sel];
      out_tdata_o[49] <= en_q[sel] && !(!sts_o.active && armed_q[sel]);
      out_tdata_o[51:50] <= 2'd0;
    end
  end

  // channel state
  logic [19:0] f, fs, fa, fr;
  logic [20:0] fsum;
  logic [23:0] dp;
  always_comb begin
    dp = decel_q[ridx_q];
    if (seek_q[ridx_q]) begin
      if (cur_q[ridx_q] >= goal_q[ridx_q]) dp = total_q[ridx_q] - left_q[ridx_q];
      else dp = {1'b0, total_q[ridx_q][23:1]};
    end
    f = cur_q[ridx_q];
    if (f > {4'd0, step_q[ridx_q]}) fs = f - {4'd0, step_q[ridx_q]};
    else fs = {4'd0, start_freq_q};
    if (fs < {4'd0, start_freq_q}) fs = {4'd0, start_freq_q};
    fsum = {1'b0, f} + {5'd0, step_q[ridx_q]};
    fa = (fsum > {1'b0, goal_q[ridx_q]}) ? goal_q[ridx_q] : fsum[19:0];
    // free run: clamp to free_max, never below 1
    fr = (goal_q[ridx_q] > free_max_q) ? free_max_q : goal_q[ridx_q];
    if (fr == '0) fr = 20'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0; prev_q <= '0; armed_q <= '0; seek_q <= '1;
      tick_q <= '0; ridx_q <= '0;
      for (int i = 0; i < Channels; i++) begin
        total_q[i] <= '0; left_q[i] <= '0; decel_q[i] <= '0;
        cur_q[i] <= {4'd0, RstStartFreq}; goal_q[i] <= 20'd1;
        step_q[i] <= '0; duty_q[i] <= '0;
      end
    end else begin
      if (cmd_i.tick_inc) tick_q <= sts_o.ramp_due ? 16'd0 : tick_inc[15:0];
      if (cmd_i.ramp_start) ridx_q <= '0;
      if (cmd_i.ramp_step) begin
        ridx_q <= ridx_q + 1'b1;
        if (!en_q[ridx_q]) begin
          cur_q[ridx_q] <= {4'd0, start_freq_q};
          seek_q[ridx_q] <= 1'b1;
        end else if (total_q[ridx_q] != '0) begin
          decel_q[ridx_q] <= dp;
          if (seek_q[ridx_q] && cur_q[ridx_q] >= goal_q[ridx_q]) seek_q[ridx_q] <= 1'b0;
          cur_q[ridx_q] <= (left_q[ridx_q] < dp) ? fs : fa;
        end else begin
          cur_q[ridx_q] <= fr;
        end
      end
      if (act_q == ActWrite && cmd_i.upd_prep) begin
        en_q[sel] <= wen_q; total_q[sel] <= wcnt_q; goal_q[sel] <= wgoal_q;
        step_q[sel] <= wstep_q; duty_q[sel] <= wduty_q;
      end
      if (act_q == ActUpdate && cmd_i.upd_prep && en_q[sel] && !prev_q[sel]) begin
        left_q[sel] <= total_q[sel];
        armed_q[sel] <= 1'b1;
      end
      if (act_q == ActUpdate && cmd_i.out_load) begin
        if (sts_o.active) begin
          if (left_q[sel] != '0) left_q[sel] <= left_q[sel] - 24'd1;
          prev_q[sel] <= en_q[sel];
        end else if (en_q[sel] && armed_q[sel]) begin
          en_q[sel] <= 1'b0; armed_q[sel] <= 1'b0; prev_q[sel] <= 1'b0;
        end else prev_q[sel] <= en_q[sel];
      end
    end
  end

  `PTRP_ASSERT_IMP(a_div_start_not_done, clk_i, rst_ni, div_start, !div_done, "divider restarted while finishing")
  `PTRP_ASSERT_NEXT(a_tick_bounded, clk_i, rst_ni, cmd_i.tick_inc && sts_o.ramp_due, tick_q == 16'd0, "divider not cleared")
  `PTRP_ASSERT_IMP(a_ramp_idx, clk_i, rst_ni, cmd_i.ramp_step, ridx_q <= LastCh, "ramp index out of range")
endmodule

[rtl/core/ptrp_ctrl.sv]
`timescale 1ns / 1ps
`include "pulse_train_ramp_timer_planner_macros.svh"
module ptrp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic [1:0]        act_i,
  input  ptrp_pkg::status_t sts_i,
  output ptrp_pkg::cmd_t    cmd_o
);
  import ptrp_pkg::*;
  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   prep_q, prep_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ov_q <= 1'b0; prep_q <= 1'b0;
    end else begin
      state_q <= state_d; ov_q <= ov_d; prep_q <= prep_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    ov_d = ov_q && !out_ready_i;
    prep_d = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = StUpdPrep;
        end
      end
      StUpdPrep: begin
        if (act_i == ActTick) begin
          cmd_o.tick_inc = 1'b1;
          cmd_o.ramp_start = 1'b1;
          state_d = sts_i.ramp_due ? StRamp : StIdle;
        end else if (!sts_i.ch_valid) begin
          state_d = StIdle;
        end else if (act_i == ActWrite) begin
          cmd_o.upd_prep = 1'b1;
          state_d = StIdle;
        end else begin
          cmd_o.upd_prep = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel = DivFreq;
          state_d = StDiv1;
        end
      end
      StRamp: begin
        cmd_o.ramp_step = 1'b1;
        if (sts_i.ramp_last) state_d = StIdle;
      end
      StDiv1: begin
        cmd_o.div_sel = DivFreq;
        if (sts_i.div_done) begin
          prep_d = 1'b1;
          state_d = StDiv2;
        end
      end
      StDiv2: begin
        cmd_o.div_sel = DivPsc;
        cmd_o.div_start = prep_q;
        if (sts_i.div_done) state_d = StMul;
      end
      StMul: begin
        cmd_o.mul_load = 1'b1;
        state_d = StRcp;
      end
      StRcp: begin
        cmd_o.rcp_load = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (!ov_q) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end
  assign out_valid_o = ov_q;

  `PTRP_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == StIdle, "ready outside idle")
  `PTRP_ASSERT_NEXT(a_out_set, clk_i, rst_ni, cmd_o.out_load, out_valid_o, "result not raised")
  `PTRP_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load, !ov_q || out_ready_i, "result overwritten")
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
import ptrp_pkg::*;

// Timer setting for one pulse, as the planner should report it.
typedef struct {
  logic [2:0]  chan;
  logic [11:0] psc;
  logic [15:0] arr;
  logic [15:0] cmp;
  logic        restart;
  logic        finished;
  logic        en_now;
} timer_set_t;

// Holds pending timer settings and compares arriving ones against them.
class timer_scoreboard;
  timer_set_t pending[$];
  int errors;

  function void note(timer_set_t t);
    pending.push_back(t);
  endfunction

  function void report(string what);
    $display("ERROR %0t: %s", $realtime, what);
    errors++;
  endfunction

  function void check(logic [55:0] d);
    timer_set_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected transfer %h", d));
      return;
    end
    e = pending.pop_front();
    if (d[2:0] !== e.chan) report($sformatf("channel %0d exp %0d", d[2:0], e.chan));
    if (d[14:3] !== e.psc) report($sformatf("prescaler %0d exp %0d", d[14:3], e.psc));
    if (d[30:15] !== e.arr) report($sformatf("reload %0d exp %0d", d[30:15], e.arr));
    if (d[46:31] !== e.cmp) report($sformatf("compare %0d exp %0d", d[46:31], e.cmp));
    if (d[47] !== e.restart) report($sformatf("restart %b exp %b", d[47], e.restart));
    if (d[48] !== e.finished) report($sformatf("finished %b exp %b", d[48], e.finished));
    if (d[49] !== e.en_now) report($sformatf("enabled %b exp %b", d[49], e.en_now));
  endfunction
endclass

module testbench;
  localparam int NCH = Channels;
  localparam longint CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [27:0] cfg_data = '0;

  pulse_train_ramp_timer_planner u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #2 clk_i = ~clk_i;

  timer_scoreboard sb = new();

  // Planner state mirror.
  logic [27:0] clk_hz;
  logic [15:0] ramp_intv;
  logic [15:0] f_start;
  logic [19:0] f_free_max;
  logic        en      [NCH];
  logic        en_prev [NCH];
  logic        armed   [NCH];
  logic [23:0] total   [NCH];
  logic [23:0] left    [NCH];
  logic [23:0] decel_at[NCH];
  logic        seeking [NCH];
  logic [19:0] freq    [NCH];
  logic [19:0] goal    [NCH];
  logic [15:0] step    [NCH];
  logic [9:0]  duty    [NCH];
  logic [15:0] divider;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  task automatic mirror_reset();
    clk_hz = RstTimerClk; ramp_intv = RstRampIntv;
    f_start = RstStartFreq; f_free_max = RstFreeMax;
    for (int c = 0; c < NCH; c++) begin
      en[c] = 0; en_prev[c] = 0; armed[c] = 0; total[c] = 0; left[c] = 0;
      decel_at[c] = 0; seeking[c] = 1; freq[c] = 20'(RstStartFreq);
      goal[c] = 1; step[c] = 0; duty[c] = 0;
    end
    divider = 0;
  endtask

  // One ramp step of one channel.
  function automatic void ramp_one(int c);
    logic [31:0] f;
    f = freq[c];
    if (!en[c]) begin
      freq[c] = 20'(f_start);
      seeking[c] = 1;
      return;
    end
    if (total[c] != 0) begin
      if (seeking[c]) begin
        if (f >= goal[c]) begin
          decel_at[c] = total[c] - left[c];
          seeking[c] = 0;
        end else decel_at[c] = total[c] / 2;
      end
      if (left[c] < decel_at[c]) begin
        if (f > step[c]) f = f - step[c];
        else f = f_start;
        if (f < f_start) f = f_start;
      end else begin
        f = f + step[c];
        if (f > goal[c]) f = goal[c];
      end
    end else begin
      f = goal[c];
      if (f > f_free_max) f = f_free_max;
      if (f < 1) f = 1;
    end
    freq[c] = f[19:0];
  endfunction

  // Applies one accepted item to the mirror; notes a timer setting if one is due.
  function automatic void plan_item(action_e act, logic [79:0] d);
    int ch;
    logic [31:0] f, dd, a, p;
    timer_set_t t;
    ch = d[2:0];
    if (act == ActTick) begin
      divider = divider + 16'd1;
      if (divider > ramp_intv) begin
        divider = 0;
        for (int c = 0; c < NCH; c++) ramp_one(c);
      end
      return;
    end
    if (act == ActNone || ch >= NCH) return;
    if (act == ActWrite) begin
      en[ch] = d[3]; total[ch] = d[27:4]; goal[ch] = d[47:28];
      step[ch] = d[63:48]; duty[ch] = d[73:64];
      return;
    end
    t.chan = 3'(ch); t.psc = IdlePrescaler; t.arr = IdleReload; t.cmp = 0;
    t.restart = 0; t.finished = 0;
    if (en[ch] && !en_prev[ch]) begin
      left[ch] = total[ch]; armed[ch] = 1; t.restart = 1;
    end
    if (!en[ch]) begin
    end else if (left[ch] != 0 || total[ch] == 0) begin
      f = (freq[ch] != 0) ? freq[ch] : 1;
      dd = (duty[ch] > Permille) ? Permille : duty[ch];
      if (left[ch] != 0) left[ch]--;
      a = clk_hz / f;
      p = a / 32'h10000;
      a = a / (p + 1);
      t.psc = p[11:0];
      t.arr = a[15:0];
      t.cmp = 16'((64'(dd) * a) / Permille);
    end else begin
      if (armed[ch]) begin
        en[ch] = 0; armed[ch] = 0;
      end
      t.finished = 1;
    end
    en_prev[ch] = en[ch];
    t.en_now = en[ch];
    sb.note(t);
  endfunction

  // Receiver: random stalls; checks each transfer.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Keeps tvalid high between back-to-back items; drops it only while idling.
  task automatic send(action_e act, logic [79:0] d);
    bit hold;
    hold = send_idle_pct != 0 && $urandom_range(99) < send_idle_pct;
    if (hold) s_axis_tvalid <= 1'b0;
    while (hold) begin
      @(posedge clk_i);
      hold = $urandom_range(99) < send_idle_pct;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    plan_item(act, d);
  endtask

  function automatic logic [79:0] job(int ch, bit e, logic [23:0] n, logic [19:0] tf,
                                      logic [15:0] acc, logic [9:0] dt);
    return {6'd0, dt, acc, tf, n, e, 3'(ch)};
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [27:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegTimerClk:  clk_hz = v;
      RegRampIntv:  ramp_intv = v[15:0];
      RegStartFreq: f_start = v[15:0];
      default:      f_free_max = v[19:0];
    endcase
    @(posedge clk_i);
  endtask

  // Mostly well-formed jobs on few channels with frequent ticks and updates.
  task automatic random_items(int n);
    int r, ch;
    logic [79:0] d;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      ch = ($urandom_range(19) == 0) ? $urandom_range(7) : $urandom_range(NCH - 1);
      d = 80'({$urandom(), $urandom(), $urandom()});
      if (r < 8) begin
        if ($urandom_range(3) == 0) d = job(ch, d[3], d[27:4], d[47:28], d[63:48], d[73:64]);
        else d = job(ch, $urandom_range(9) != 0,
                     ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(40)),
                     20'($urandom_range(1, 3000)), 16'($urandom_range(500)),
                     10'($urandom_range(1023)));
        send(ActWrite, d);
      end else if (r < 45) send(ActTick, d);
      else if (r < 97) send(ActUpdate, {d[79:3], 3'(ch)});
      else send(ActNone, d);
    end
  endtask

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("pulse_train_ramp_timer_planner: mismatch");
      $finish;
    end
  end

  initial begin
    mirror_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, every action, odd channels, duty above 1000.
    write_reg(RegRampIntv, 28'd0);
    send(ActUpdate, job(0, 0, 0, 1, 0, 0));
    send(ActWrite, job(0, 1, 24'd3, 20'd1000, 16'd300, 10'd500));
    send(ActWrite, job(1, 1, 24'd0, 20'hFFFFF, 16'hFFFF, 10'h3FF));
    send(ActWrite, job(2, 1, 24'hFFFFFF, 20'd0, 16'd0, 10'd1000));
    send(ActWrite, job(7, 1, 24'd5, 20'd5, 16'd5, 10'd5));
    send(ActWrite, job(NCH - 1, 1, 24'd1, 20'd1, 16'd1, 10'd0));
    for (int k = 0; k < 5; k++) begin
      send(ActUpdate, job(0, 0, 0, 0, 0, 0));
      send(ActTick, '1);
    end
    send(ActUpdate, job(1, 0, 0, 0, 0, 0));
    send(ActUpdate, job(2, 0, 0, 0, 0, 0));
    send(ActUpdate, job(6, 0, 0, 0, 0, 0));
    send(ActUpdate, job(NCH - 1, 0, 0, 0, 0, 0));
    send(ActUpdate, job(NCH - 1, 0, 0, 0, 0, 0));
    send(ActUpdate, job(NCH - 1, 0, 0, 0, 0, 0));
    send(ActNone, '1);
    wait_drained();

    // Phases: each sets some registers, then runs random traffic with idling and stalls.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      case (ph)
        0: begin write_reg(RegTimerClk, 28'd200000000); write_reg(RegStartFreq, 28'd0); end
        1: begin write_reg(RegTimerClk, 28'd1); write_reg(RegStartFreq, 28'd65535); end
        2: write_reg(RegRampIntv, 28'd65535);
        3: begin write_reg(RegFreeMax, 28'd1); write_reg(RegTimerClk, 28'hFFFFFFF); end
        4: write_reg(RegFreeMax, 28'hFFFFF);
        default: begin
          write_reg(RegTimerClk, RstTimerClk); write_reg(RegStartFreq, 28'd1);
        end
      endcase
      write_reg(RegRampIntv, ph == 2 ? 28'd65535 : 28'($urandom_range(3)));
      random_items(120);
      send_idle_pct = 0;
      wait_drained();
      random_items(130);
      wait_drained();
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("pulse_train_ramp_timer_planner: match");
    else
      $display("pulse_train_ramp_timer_planner: mismatch");
    $finish;
  end
endmodule
